[rtl/core/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the comment stripper
// Character codes, config register map, queue geometry, scan modes, the push
// bundle from the step logic to the output queue, and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // config register map (byte addresses)
  localparam int unsigned        ADDR_W        = 3;
  localparam logic [ADDR_W-1:0]  REG_COLLAPSE  = 3'd0;
  localparam logic               COLLAPSE_RST  = 1'b1;

  // output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // scan modes, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_SLASH  = 5'b00010,
    MODE_LINE   = 5'b00100,
    MODE_BLOCK  = 5'b01000,
    MODE_BSTAR  = 5'b10000
  } ccs_mode_t;

  // results of one processed byte, up to two
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } ccs_push_t;

  // one queued output beat
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } ccs_entry_t;

endpackage

`default_nettype wire

[rtl/core/ccs_cfg.sv]
// ----------------------------------------------------------------------------
// ccs_cfg: configuration register file
// APB-style slave holding the blank-line collapse enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ccs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic                            collapse
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // collapse enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      collapse <= ccs_pkg::COLLAPSE_RST;
    end else if (wr_en && paddr == ccs_pkg::REG_COLLAPSE) begin
      collapse <= pwdata[0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (paddr)
      ccs_pkg::REG_COLLAPSE: prdata = {31'd0, collapse};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ccs_step.sv]
// ----------------------------------------------------------------------------
// ccs_step: input register and per-byte scan logic
// Holds one input beat, advances the scan mode and produces up to two
// output bytes for the queue in a single cycle while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          collapse,
  input  wire logic          room,
  output ccs_pkg::ccs_push_t push
);

  logic               in_vld;
  logic [7:0]         in_b;
  logic               in_fin;
  logic               adv;
  ccs_pkg::ccs_mode_t mode, mode_next;
  logic               lwn, lwn_next;
  ccs_pkg::ccs_push_t res;
  logic               nl_b;
  logic               nl_drop;

  assign adv      = in_vld && room;
  assign s_tready = !in_vld || room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_b   <= s_tdata;
      in_fin <= s_tlast;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ccs_pkg::MODE_NORMAL;
      lwn  <= 1'b0;
    end else if (adv) begin
      mode <= mode_next;
      lwn  <= lwn_next;
    end
  end

  assign nl_b    = (in_b == ccs_pkg::CH_NL);
  // a newline right after an emitted newline is dropped when collapsing
  assign nl_drop = nl_b && lwn && collapse;

  // next mode and emitted bytes
  always_comb begin
    mode_next = mode;
    lwn_next  = lwn;
    res       = '0;
    unique case (mode)
      ccs_pkg::MODE_SLASH: begin
        if (in_b == ccs_pkg::CH_SLASH) begin
          mode_next = ccs_pkg::MODE_LINE;
        end else if (in_b == ccs_pkg::CH_STAR) begin
          mode_next = ccs_pkg::MODE_BLOCK;
        end else begin
          // release the held slash, then the byte as plain text
          mode_next = ccs_pkg::MODE_NORMAL;
          res.cnt   = 2'd2;
          res.b0    = ccs_pkg::CH_SLASH;
          res.b1    = in_b;
          lwn_next  = nl_b;
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (nl_b) begin
          mode_next = ccs_pkg::MODE_NORMAL;
          if (!nl_drop) begin
            res.cnt  = 2'd1;
            res.b0   = in_b;
            lwn_next = 1'b1;
          end
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (in_b == ccs_pkg::CH_STAR) begin
          mode_next = ccs_pkg::MODE_BSTAR;
        end
      end
      ccs_pkg::MODE_BSTAR: begin
        if (in_b == ccs_pkg::CH_SLASH) begin
          mode_next = ccs_pkg::MODE_NORMAL;
        end else if (in_b != ccs_pkg::CH_STAR) begin
          mode_next = ccs_pkg::MODE_BLOCK;
        end
      end
      default: begin
        // normal text, also any stray code
        mode_next = ccs_pkg::MODE_NORMAL;
        if (in_b == ccs_pkg::CH_SLASH) begin
          mode_next = ccs_pkg::MODE_SLASH;
        end else if (!nl_drop) begin
          res.cnt  = 2'd1;
          res.b0   = in_b;
          lwn_next = nl_b;
        end
      end
    endcase

    // end of text: flush a held slash and return to the start state
    if (in_fin) begin
      if (mode_next == ccs_pkg::MODE_SLASH) begin
        res.cnt = 2'd1;
        res.b0  = ccs_pkg::CH_SLASH;
      end
      mode_next = ccs_pkg::MODE_NORMAL;
      lwn_next  = 1'b0;
    end
  end

  always_comb begin
    push = res;
    if (!adv) begin
      push.cnt = 2'd0;
    end
  end

  // the final byte leaves the scanner in its start state
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    adv && in_fin |=> mode == ccs_pkg::MODE_NORMAL && !lwn)
    else $error("scan state not cleared after final byte");

  // two results only ever come from releasing a held slash
  a_two_from_slash: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 |-> mode == ccs_pkg::MODE_SLASH && push.b0 == ccs_pkg::CH_SLASH)
    else $error("double result outside held slash");

endmodule

`default_nettype wire

[rtl/core/ccs_out_fifo.sv]
// ----------------------------------------------------------------------------
// ccs_out_fifo: output queue
// Four-entry register queue taking up to two bytes per cycle while it has
// room and handing out one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ccs_pkg::ccs_push_t push,
  output logic                    room,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [7:0]              m_tdata,
  output logic                    m_tlast
);

  ccs_pkg::ccs_entry_t             mem [ccs_pkg::QDEPTH];
  logic [ccs_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ccs_pkg::QPTR_W-1:0]      wr_ptr1;
  logic [ccs_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ccs_pkg::QCNT_W-1:0]      count;
  logic                            pop;

  // room for two more beats
  assign room     = count <= ccs_pkg::QCNT_W'(ccs_pkg::QDEPTH - 2);
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign wr_ptr1  = wr_ptr + ccs_pkg::QPTR_W'(1);

  // entry writes; run_last on the final byte of each push
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= '{last: (push.cnt == 2'd1), data: push.b0};
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= '{last: 1'b1, data: push.b1};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ccs_pkg::QPTR_W'(push.cnt);
      rd_ptr <= rd_ptr + ccs_pkg::QPTR_W'(pop);
      count  <= count + ccs_pkg::QCNT_W'(push.cnt) - ccs_pkg::QCNT_W'(pop);
    end
  end

  assign m_tdata = mem[rd_ptr].data;
  assign m_tlast = mem[rd_ptr].last;

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= ccs_pkg::QCNT_W'(ccs_pkg::QDEPTH))
    else $error("output queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("push without room");

endmodule

`default_nettype wire

[rtl/core/comment_stripper_blank_collapse_unit.sv]
// An input beat passes the input register, then the output queue.
// Throughput: one input byte per cycle while the queue has room; the output
// drains one beat per cycle from a four-entry queue while m_tready is high,
// so a released slash (two bytes) costs one extra output beat. Reset (rst,
// synchronous) clears the scan state, the queue and sets collapse to 1.
// ----------------------------------------------------------------------------
// comment_stripper_blank_collapse_unit: C comment stripper
// Drops line and block comments from a byte stream and optionally folds
// runs of newlines into one.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_stripper_blank_collapse_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,   // [7:0] in_byte
  input  wire logic                       s_tlast,   // is_final
  // output stream
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tlast,   // run_last
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ccs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic               collapse;
  logic               room;
  ccs_pkg::ccs_push_t push;

  ccs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .collapse (collapse)
  );

  ccs_step u_step (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .collapse (collapse),
    .room     (room),
    .push     (push)
  );

  ccs_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the C comment stripper
// Streams source text into the unit one byte per beat and checks every
// cleaned output byte against a cycle-free predictor of the stripper kept in
// step with the accepted input. A directed table exercises the reset collapse
// setting, held slashes, both comment kinds and end-of-text handling. Random
// text made of words, comments, blank runs and noise follows under varying
// idle patterns and both settings of blank-line collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_RUN = 275;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_DIRECTED    = 26;

  // directed row: input byte, final flag, and optionally typed-in results
  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         typed;
    int         count;
    logic [7:0] out0;
    logic [7:0] out1;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tlast = 1'b0;    // is_final
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] out_byte
  logic        m_tlast;           // run_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ccs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // stripper state mirrored by the predictor
  ccs_pkg::ccs_mode_t scan_state = ccs_pkg::MODE_NORMAL;
  logic        at_newline = 1'b0;
  logic        collapse_on = ccs_pkg::COLLAPSE_RST;
  logic [7:0]  step_bytes[$];

  ccs_pkg::ccs_entry_t stripped_q[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  text_row_t directed_rows [N_DIRECTED] = '{
    '{ccs_pkg::CH_NL,    1'b0, 1'b1, 1, ccs_pkg::CH_NL,    8'h00},  // first newline kept
    '{ccs_pkg::CH_NL,    1'b0, 1'b1, 0, 8'h00,             8'h00},  // repeat folded
    '{8'h61,             1'b0, 1'b1, 1, 8'h61,             8'h00},
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b1, 0, 8'h00,             8'h00},  // slash held back
    '{8'h62,             1'b0, 1'b1, 2, ccs_pkg::CH_SLASH, 8'h62},  // slash plus byte
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},  // line comment
    '{8'hFF,             1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_NL,    1'b0, 1'b0, 0, 8'h00,             8'h00},  // newline kept
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},  // block comment
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},  // stays open
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{8'h71,             1'b0, 1'b0, 0, 8'h00,             8'h00},  // back inside
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},  // star-slash closes
    '{8'h00,             1'b0, 1'b1, 1, 8'h00,             8'h00},
    '{ccs_pkg::CH_SLASH, 1'b1, 1'b1, 1, ccs_pkg::CH_SLASH, 8'h00},  // final flushes
    '{ccs_pkg::CH_NL,    1'b0, 1'b1, 1, ccs_pkg::CH_NL,    8'h00},  // new text
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_NL,    1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_SLASH, 1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{ccs_pkg::CH_STAR,  1'b0, 1'b0, 0, 8'h00,             8'h00},
    '{8'hFF,             1'b1, 1'b1, 0, 8'h00,             8'h00}   // unterminated
  };

  comment_stripper_blank_collapse_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void emit_byte(input logic [7:0] b);
    if (b == ccs_pkg::CH_NL && at_newline && collapse_on)
      return;
    step_bytes.push_back(b);
    at_newline = (b == ccs_pkg::CH_NL);
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == ccs_pkg::CH_SLASH)
      scan_state = ccs_pkg::MODE_SLASH;
    else
      emit_byte(b);
  endfunction

  // one input byte -> step_bytes
  function automatic void strip_step(input logic [7:0] b, input logic fin);
    step_bytes.delete();
    case (scan_state)
      ccs_pkg::MODE_SLASH: begin
        if (b == ccs_pkg::CH_SLASH) begin
          scan_state = ccs_pkg::MODE_LINE;
        end else if (b == ccs_pkg::CH_STAR) begin
          scan_state = ccs_pkg::MODE_BLOCK;
        end else begin
          scan_state = ccs_pkg::MODE_NORMAL;
          emit_byte(ccs_pkg::CH_SLASH);
          plain_byte(b);
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (b == ccs_pkg::CH_NL) begin
          scan_state = ccs_pkg::MODE_NORMAL;
          emit_byte(b);
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (b == ccs_pkg::CH_STAR)
          scan_state = ccs_pkg::MODE_BSTAR;
      end
      ccs_pkg::MODE_BSTAR: begin
        if (b == ccs_pkg::CH_SLASH)
          scan_state = ccs_pkg::MODE_NORMAL;
        else if (b != ccs_pkg::CH_STAR)
          scan_state = ccs_pkg::MODE_BLOCK;
      end
      default: begin
        scan_state = ccs_pkg::MODE_NORMAL;
        plain_byte(b);
      end
    endcase
    // end of text: flush a held slash, start the next text clean
    if (fin) begin
      if (scan_state == ccs_pkg::MODE_SLASH)
        emit_byte(ccs_pkg::CH_SLASH);
      scan_state = ccs_pkg::MODE_NORMAL;
      at_newline = 1'b0;
    end
  endfunction

  function automatic void queue_step_bytes();
    ccs_pkg::ccs_entry_t ent;
    foreach (step_bytes[i]) begin
      ent.data = step_bytes[i];
      ent.last = (i == step_bytes.size() - 1);
      stripped_q.push_back(ent);
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------- stimulus
  // one input beat, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (stripped_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccs_pkg::ADDR_W-1:0] addr,
                           input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ccs_pkg::REG_COLLAPSE)
      collapse_on = value[0];
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(3) == 0)
      return 8'h20;
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] comment_char();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2)
      return ccs_pkg::CH_STAR;
    if (pick == 2)
      return ccs_pkg::CH_SLASH;
    if (pick == 3)
      return ccs_pkg::CH_NL;
    return 8'($urandom_range(126, 32));
  endfunction

  // a random piece of source text: mostly well-formed, some noise
  task automatic send_snippet();
    logic [7:0] text[$];
    int         kind;
    int         len;
    logic       fin;
    kind = $urandom_range(99);
    len  = $urandom_range(8, 1);
    if (kind < 35) begin
      repeat (len) text.push_back(word_char());
      text.push_back(($urandom_range(1) == 0) ? ccs_pkg::CH_NL : 8'h20);
    end else if (kind < 55) begin
      text.push_back(ccs_pkg::CH_SLASH);
      text.push_back(ccs_pkg::CH_SLASH);
      repeat (len)
        text.push_back(($urandom_range(4) == 0) ? ccs_pkg::CH_STAR : word_char());
      text.push_back(ccs_pkg::CH_NL);
    end else if (kind < 75) begin
      text.push_back(ccs_pkg::CH_SLASH);
      text.push_back(ccs_pkg::CH_STAR);
      repeat (len) text.push_back(comment_char());
      text.push_back(ccs_pkg::CH_STAR);
      text.push_back(ccs_pkg::CH_SLASH);
    end else if (kind < 85) begin
      repeat (len) text.push_back(ccs_pkg::CH_NL);
    end else begin
      repeat (len) text.push_back(8'($urandom_range(255)));
    end
    foreach (text[i]) begin
      fin = ($urandom_range(49) == 0);
      send_beat(text[i], fin);
      strip_step(text[i], fin);
      queue_step_bytes();
    end
  endtask

  // output receiver stalls
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // output check
  always @(posedge clk) begin : out_check
    ccs_pkg::ccs_entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (stripped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%02h last=%0b", m_tdata, m_tlast));
      end else begin
        want = stripped_q.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.last)
          report_mismatch($sformatf("data exp %02h got %02h, last exp %0b got %0b",
                                    want.data, m_tdata, want.last, m_tlast));
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // main sequence
  initial begin : main_seq
    ccs_pkg::ccs_entry_t ent;
    int         target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset setting of blank-line collapse
    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].data, directed_rows[r].fin);
      strip_step(directed_rows[r].data, directed_rows[r].fin);
      if (directed_rows[r].typed) begin
        if (directed_rows[r].count > 0) begin
          ent.data = directed_rows[r].out0;
          ent.last = (directed_rows[r].count == 1);
          stripped_q.push_back(ent);
        end
        if (directed_rows[r].count > 1) begin
          ent.data = directed_rows[r].out1;
          ent.last = 1'b1;
          stripped_q.push_back(ent);
        end
      end else begin
        queue_step_bytes();
      end
    end

    // random runs: collapse off, on, off; idle patterns per run
    target = items_sent;
    for (int run = 0; run < 3; run++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (run)
        0: begin
          write_reg(ccs_pkg::REG_COLLAPSE, 32'h0000_0000);
          tx_idle_pct = 7;
          rx_idle_pct = 74;
        end
        1: begin
          write_reg(ccs_pkg::REG_COLLAPSE, 32'hFFFF_FFFF);
          tx_idle_pct = 74;
          rx_idle_pct = 7;
        end
        default: begin
          write_reg(ccs_pkg::REG_COLLAPSE, 32'hFFFF_FFFE);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      target += ITEMS_PER_RUN;
      while (items_sent < target) begin
        send_snippet();
        // hold the input until the output side has caught up, midway through the first run
        if (run == 0 && items_sent >= target - ITEMS_PER_RUN / 2 &&
            items_sent < target - ITEMS_PER_RUN / 2 + 8)
          drain_results();
      end
      // close the text so the next run starts clean
      send_beat(8'h7A, 1'b1);
      strip_step(8'h7A, 1'b1);
      queue_step_bytes();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
